### sv/rsa_modular_exponentiation_defines.svh
// assertion macros used by the checker file rsa_mexp_checker.sv
`ifndef RSA_MODULAR_EXPONENTIATION_DEFINES_SVH
`define RSA_MODULAR_EXPONENTIATION_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define RSA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsa modexp check failed");

// consequent must hold in the cycle after the antecedent
`define RSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsa modexp check failed");

`endif

### sv/rsa_mexp_pkg.sv
// shared constants and types for the rsa modular exponentiation block
package rsa_mexp_pkg;

   localparam int VALUE_BITS     = 16;
   localparam int RESULT_BITS    = 16;
   localparam int REG_INDEX_BITS = 2;
   localparam int MODULUS_MIN    = 2;

   typedef logic [REG_INDEX_BITS-1:0] reg_index_type;

   localparam reg_index_type REG_MODULUS  = 2'd0;
   localparam reg_index_type REG_ENCRYPT  = 2'd1;
   localparam reg_index_type REG_DECRYPT  = 2'd2;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage

### sv/rsa_mexp_modmul.sv
// bit-serial modular multiplier: one multiplier bit per cycle, msb first
module rsa_mexp_modmul #(
   parameter int WORD_BITS = 16,
   parameter int B_BITS    = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [WORD_BITS-1:0]        multiplicand,
   input  logic [B_BITS-1:0]           multiplier,
   input  logic [WORD_BITS-1:0]        modulus,
   output logic [WORD_BITS-1:0]        product,
   output rsa_mexp_pkg::mul_status_type status
);
   import rsa_mexp_pkg::*;

   localparam int CNT_BITS = $clog2(B_BITS + 1);
   localparam int SUM_BITS = WORD_BITS + 2;

   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] a_ff;
   logic [WORD_BITS-1:0] m_ff;
   logic [B_BITS-1:0]    b_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [SUM_BITS-1:0]  sum;
   logic [SUM_BITS-1:0]  m_once;
   logic [SUM_BITS-1:0]  m_twice;
   logic [SUM_BITS-1:0]  reduced;

   // acc < m and a < m, so 2*acc + a stays below 3*m
   always_comb begin
      sum     = {1'b0, acc_ff, 1'b0} + SUM_BITS'(b_ff[B_BITS-1] ? a_ff : '0);
      m_once  = {2'b00, m_ff};
      m_twice = {1'b0, m_ff, 1'b0};
      if (sum >= m_twice) begin
         reduced = sum - m_twice;
      end else if (sum >= m_once) begin
         reduced = sum - m_once;
      end else begin
         reduced = sum;
      end
      acc_in = reduced[WORD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(B_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         a_ff   <= multiplicand;
         m_ff   <= modulus;
         b_ff   <= multiplier;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         b_ff   <= {b_ff[B_BITS-2:0], 1'b0};
      end
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

### sv/rsa_modular_exponentiation.sv
// rsa modular exponentiation: right-to-left square and multiply on a serial multiplier
//
//   channel  dir  handshake                 payload
//   req      in   req_tvalid / req_tready   tdata: value, tuser: operation
//   rsp      out  rsp_tvalid / rsp_tready   tdata: result
//   csr      in   psel / penable / pready   modulus, encrypt and decrypt exponent
//
// one request at a time; every modular product runs on the shared bit-serial multiplier
// (B_BITS is the wider of WORD_BITS and the value), and a request needs one reduction
// plus at most 2*WORD_BITS - 1 products, depending on the exponent's bits.
// reset is synchronous; it clears control and sets the modulus to two and both exponents to one.
// a finished result waits in the output register while the next request is taken;
// the last state holds while an earlier result is still stalled there.
module rsa_modular_exponentiation #(
   parameter  int WORD_BITS      = 16,
   localparam int CSR_DATA_BITS  = (WORD_BITS > 32) ? 64 : 32,
   localparam int CSR_ADDR_SHIFT = (WORD_BITS > 32) ? 3 : 2,
   localparam int CSR_ADDR_BITS  = CSR_ADDR_SHIFT + rsa_mexp_pkg::REG_INDEX_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rsa_mexp_pkg::VALUE_BITS-1:0] req_tdata,  // value
   input  logic                                req_tuser,  // operation
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rsa_mexp_pkg::RESULT_BITS-1:0] rsp_tdata, // result
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]            csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]            csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]            csr_prdata,
   output logic                                csr_pready
);
   import rsa_mexp_pkg::*;

   localparam int B_BITS = (WORD_BITS > VALUE_BITS) ? WORD_BITS : VALUE_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_STEP   = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_SQR    = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [WORD_BITS-1:0]   ex_ff, ex_in;
   logic [WORD_BITS-1:0]   acc_ff, acc_in;
   logic [WORD_BITS-1:0]   sq_ff, sq_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RESULT_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic [WORD_BITS-1:0]   modulus_ff;
   logic [WORD_BITS-1:0]   encrypt_ff;
   logic [WORD_BITS-1:0]   decrypt_ff;

   logic                   req_accept;
   logic                   mul_start;
   logic [WORD_BITS-1:0]   mul_a;
   logic [B_BITS-1:0]      mul_b;
   logic [WORD_BITS-1:0]   mul_product;
   mul_status_type         mul_status;

   logic                   csr_write;
   reg_index_type          csr_index;
   logic [WORD_BITS-1:0]   csr_wvalue;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;

   rsa_mexp_modmul #(
      .WORD_BITS (WORD_BITS),
      .B_BITS    (B_BITS)
   ) u_modmul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (mul_a),
      .multiplier   (mul_b),
      .modulus      (modulus_ff),
      .product      (mul_product),
      .status       (mul_status)
   );

   always_comb begin
      state_in      = state_ff;
      ex_in         = ex_ff;
      acc_in        = acc_ff;
      sq_in         = sq_ff;
      mul_start     = 1'b0;
      mul_a         = sq_ff;
      mul_b         = B_BITS'(sq_ff);
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      case (state_ff)
         ST_IDLE: begin
            // value mod m comes out of 1 * value on the multiplier
            mul_a = WORD_BITS'(1);
            mul_b = B_BITS'(req_tdata);
            if (req_accept) begin
               mul_start = 1'b1;
               acc_in    = WORD_BITS'(1);
               ex_in     = (req_tuser == OP_DECRYPT) ? decrypt_ff : encrypt_ff;
               state_in  = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mul_status.done) begin
               sq_in    = mul_product;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (ex_ff == '0) begin
               state_in = ST_DONE;
            end else if (ex_ff[0]) begin
               mul_a     = acc_ff;
               mul_start = 1'b1;
               state_in  = ST_MUL;
            end else begin
               mul_start = 1'b1;
               state_in  = ST_SQR;
            end
         end
         ST_MUL: begin
            if (mul_status.done) begin
               acc_in   = mul_product;
               ex_in    = {ex_ff[WORD_BITS-1:1], 1'b0};
               state_in = ST_STEP;
            end
         end
         ST_SQR: begin
            if (mul_status.done) begin
               sq_in    = mul_product;
               ex_in    = ex_ff >> 1;
               state_in = ST_STEP;
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RESULT_BITS'(acc_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      ex_ff        <= ex_in;
      acc_ff       <= acc_in;
      sq_ff        <= sq_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // configuration registers
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:CSR_ADDR_SHIFT];
   assign csr_wvalue = csr_pwdata[WORD_BITS-1:0];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= WORD_BITS'(MODULUS_MIN);
         encrypt_ff <= WORD_BITS'(1);
         decrypt_ff <= WORD_BITS'(1);
      end else if (csr_write) begin
         case (csr_index)
            REG_MODULUS: begin
               // a modulus below two is refused
               if (csr_wvalue >= WORD_BITS'(MODULUS_MIN)) begin
                  modulus_ff <= csr_wvalue;
               end
            end
            REG_ENCRYPT: begin
               encrypt_ff <= csr_wvalue;
            end
            REG_DECRYPT: begin
               decrypt_ff <= csr_wvalue;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_MODULUS: csr_prdata = CSR_DATA_BITS'(modulus_ff);
         REG_ENCRYPT: csr_prdata = CSR_DATA_BITS'(encrypt_ff);
         REG_DECRYPT: csr_prdata = CSR_DATA_BITS'(decrypt_ff);
         default:     csr_prdata = '0;
      endcase
   end

endmodule

### sv/rsa_mexp_checker.sv
// port-level checks for the rsa modular exponentiation block, bound to the top level
`include "rsa_modular_exponentiation_defines.svh"

module rsa_mexp_checker #(
   parameter  int WORD_BITS      = 16,
   localparam int CSR_DATA_BITS  = (WORD_BITS > 32) ? 64 : 32,
   localparam int CSR_ADDR_SHIFT = (WORD_BITS > 32) ? 3 : 2,
   localparam int CSR_ADDR_BITS  = CSR_ADDR_SHIFT + rsa_mexp_pkg::REG_INDEX_BITS
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [rsa_mexp_pkg::RESULT_BITS-1:0] rsp_tdata,
   input logic                                 csr_psel,
   input logic                                 csr_pwrite,
   input logic [CSR_ADDR_BITS-1:0]             csr_paddr,
   input logic [CSR_DATA_BITS-1:0]             csr_prdata
);
   import rsa_mexp_pkg::*;

   logic modulus_read;

   assign modulus_read = csr_psel & ~csr_pwrite &
                         (csr_paddr[CSR_ADDR_BITS-1:CSR_ADDR_SHIFT] == REG_MODULUS);

   // a stalled result keeps its value
   `RSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))

   // one request at a time: busy right after taking one
   `RSA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

   // a new result shows up just as the block frees itself
   `RSA_ASSERT_NOW(a_ready_with_result, clock, reset, $rose(rsp_tvalid), req_tready)

   // the modulus never reads back below two
   `RSA_ASSERT_NOW(a_modulus_floor, clock, reset, modulus_read,
                   csr_prdata >= CSR_DATA_BITS'(MODULUS_MIN))

endmodule

bind rsa_modular_exponentiation rsa_mexp_checker #(
   .WORD_BITS (WORD_BITS)
) u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_psel   (csr_psel),
   .csr_pwrite (csr_pwrite),
   .csr_paddr  (csr_paddr),
   .csr_prdata (csr_prdata)
);

### sim/rsa_mexp_scoreboard.sv
`timescale 1ns / 100ps
// checker for the rsa modular exponentiation block: tracks register writes, predicts and compares
module rsa_mexp_scoreboard #(
   parameter int REG_BITS      = 16,
   parameter int CSR_ADDR_BITS = 4,
   parameter int CSR_DATA_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [rsa_mexp_pkg::VALUE_BITS-1:0]  req_tdata,  // value
   input  logic                                 req_tuser,  // operation
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [rsa_mexp_pkg::RESULT_BITS-1:0] rsp_tdata,  // result
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]             csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]             csr_pwdata,
   input  logic                                 csr_pready,
   output int                                   mismatch_count,
   output int                                   pending_count
);
   import rsa_mexp_pkg::*;

   typedef struct packed {
      logic                   op;
      logic [VALUE_BITS-1:0]  value;
      logic [RESULT_BITS-1:0] result;
   } due_result_type;

   due_result_type results_due[$];

   logic [REG_BITS-1:0] n_mod;
   logic [REG_BITS-1:0] e_pub;
   logic [REG_BITS-1:0] d_priv;
   int                  fail_tally = 0;

   // right-to-left square and multiply; products fit in 32 bits
   function automatic logic [RESULT_BITS-1:0] modexp(input logic [VALUE_BITS-1:0] base,
                                                     input logic [REG_BITS-1:0] power,
                                                     input logic [REG_BITS-1:0] modn);
      logic [31:0]         acc;
      logic [31:0]         sq;
      logic [REG_BITS-1:0] bits_left;
      if (power == 0)
         return RESULT_BITS'(1);
      acc       = 32'd1;
      sq        = 32'(base) % 32'(modn);
      bits_left = power;
      while (bits_left != 0) begin
         if (bits_left[0])
            acc = (acc * sq) % 32'(modn);
         sq        = (sq * sq) % 32'(modn);
         bits_left = bits_left >> 1;
      end
      return acc[RESULT_BITS-1:0];
   endfunction

   always @(posedge clock) begin
      due_result_type      entry;
      logic [REG_BITS-1:0] wdata;
      reg_index_type       widx;
      if (reset) begin
         results_due.delete();
         n_mod  = REG_BITS'(MODULUS_MIN);
         e_pub  = REG_BITS'(1);
         d_priv = REG_BITS'(1);
      end else begin
         // responses first: a result can never belong to a request taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               fail_tally++;
               if (fail_tally <= 10)
                  $display("%0t: result %0d arrived with no request outstanding",
                           $realtime, rsp_tdata);
            end else begin
               entry = results_due.pop_front();
               if (rsp_tdata !== entry.result) begin
                  fail_tally++;
                  if (fail_tally <= 10)
                     $display("%0t: op %0d value %0d: expected %0d, got %0d", $realtime,
                              entry.op, entry.value, entry.result, rsp_tdata);
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            wdata = csr_pwdata[REG_BITS-1:0];
            widx  = csr_paddr[CSR_ADDR_BITS-1:CSR_ADDR_BITS-REG_INDEX_BITS];
            case (widx)
               REG_MODULUS: begin
                  // moduli below two are refused
                  if (wdata >= MODULUS_MIN)
                     n_mod = wdata;
               end
               REG_ENCRYPT: e_pub = wdata;
               REG_DECRYPT: d_priv = wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            entry.op     = req_tuser;
            entry.value  = req_tdata;
            entry.result = modexp(req_tdata, (req_tuser == OP_DECRYPT) ? d_priv : e_pub, n_mod);
            results_due.push_back(entry);
         end
      end
      pending_count  <= results_due.size();
      mismatch_count <= fail_tally;
   end

endmodule

### sim/tb_rsa_modular_exponentiation.sv
`timescale 1ns / 100ps
// stimulus and verdict for the rsa modular exponentiation block
module tb_rsa_modular_exponentiation;
   import rsa_mexp_pkg::*;

   localparam int WORD_BITS     = 16;
   localparam int CSR_ADDR_BITS = 2 + REG_INDEX_BITS;
   localparam int CSR_DATA_BITS = 32;
   localparam int RANDOM_PHASES = 20;
   localparam int PHASE_ITEMS   = 50;
   localparam int DRAIN_CYCLES  = 40;
   localparam int RUN_LIMIT     = 8000000;

   // address slot past the last register
   localparam reg_index_type REG_SPARE = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [VALUE_BITS-1:0]    req_tdata;   // value
   logic                     req_tuser;   // operation
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RESULT_BITS-1:0]   rsp_tdata;   // result
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int mismatch_count;
   int pending_count;
   bit idle_on = 1'b1;
   int stall_left = 0;

   always #10 clock = ~clock;

   rsa_modular_exponentiation #(.WORD_BITS(WORD_BITS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   rsa_mexp_scoreboard #(
      .REG_BITS      (WORD_BITS),
      .CSR_ADDR_BITS (CSR_ADDR_BITS),
      .CSR_DATA_BITS (CSR_DATA_BITS)
   ) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // mostly short gaps, a few long enough to span a whole exponentiation
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 20);
      return $urandom_range(50, 700);
   endfunction

   function automatic logic [WORD_BITS-1:0] pick_modulus();
      case ($urandom_range(0, 7))
         0:       return WORD_BITS'(MODULUS_MIN);
         1:       return 16'hFFFF;
         2, 3:    return WORD_BITS'($urandom_range(3, 255));
         default: return WORD_BITS'($urandom_range(2, 65535));
      endcase
   endfunction

   function automatic logic [WORD_BITS-1:0] pick_exponent();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return 16'hFFFF;
         3, 4:    return WORD_BITS'($urandom_range(2, 255));
         default: return WORD_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value(input logic [WORD_BITS-1:0] modn);
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return modn - 16'd1;
         3:       return modn;
         4:       return modn + 16'd1;
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   // upper data bits are random: the register only keeps the low word
   task automatic csr_write(input reg_index_type index, input logic [WORD_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {16'($urandom), data};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_request(input logic op, input logic [VALUE_BITS-1:0] val);
      int gap;
      gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= val;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off new requests until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic load_keys(input logic [WORD_BITS-1:0] modn, input logic [WORD_BITS-1:0] e,
                            input logic [WORD_BITS-1:0] d);
      csr_write(REG_MODULUS, modn);
      csr_write(REG_ENCRYPT, e);
      csr_write(REG_DECRYPT, d);
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int                   phase;
      int                   item;
      logic [WORD_BITS-1:0] stim_modulus;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= OP_ENCRYPT;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at their reset values: modulus two, both exponents one
      send_request(OP_ENCRYPT, 16'd0);
      send_request(OP_ENCRYPT, 16'hFFFF);
      send_request(OP_DECRYPT, 16'd1);
      send_request(OP_DECRYPT, 16'hFFFE);
      drain();

      // refused modulus writes and the empty slot leave the modulus at two
      csr_write(REG_MODULUS, 16'd0);
      csr_write(REG_MODULUS, 16'd1);
      csr_write(REG_SPARE, 16'hA5A5);
      csr_write(REG_ENCRYPT, 16'd0);
      csr_write(REG_DECRYPT, 16'hFFFF);
      send_request(OP_ENCRYPT, 16'd12345);
      send_request(OP_DECRYPT, 16'd3);
      send_request(OP_DECRYPT, 16'hFFFF);
      drain();

      load_keys(16'hFFFF, 16'hFFFF, 16'd2);
      send_request(OP_ENCRYPT, 16'hFFFF);
      send_request(OP_ENCRYPT, 16'd2);
      send_request(OP_DECRYPT, 16'hFFFE);
      send_request(OP_DECRYPT, 16'd0);
      send_request(OP_ENCRYPT, 16'hFFFE);
      drain();

      // textbook key pair; one element above the modulus
      load_keys(16'd3233, 16'd17, 16'd2753);
      send_request(OP_ENCRYPT, 16'd65);
      send_request(OP_DECRYPT, 16'd2790);
      send_request(OP_ENCRYPT, 16'd5000);
      send_request(OP_DECRYPT, 16'd0);
      drain();

      // zero to the zero power still gives one
      load_keys(16'd65521, 16'd0, 16'd1);
      send_request(OP_ENCRYPT, 16'd0);
      send_request(OP_DECRYPT, 16'hFFFF);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         stim_modulus = pick_modulus();
         csr_write(REG_MODULUS, stim_modulus);
         if ($urandom_range(0, 3) == 0)
            csr_write(REG_MODULUS, WORD_BITS'($urandom_range(0, 1)));
         csr_write(REG_ENCRYPT, pick_exponent());
         csr_write(REG_DECRYPT, pick_exponent());
         if ($urandom_range(0, 3) == 0)
            csr_write(REG_SPARE, WORD_BITS'($urandom));
         // every fourth phase runs back to back
         idle_on <= (phase % 4 != 3);
         for (item = 0; item < PHASE_ITEMS; item++) begin
            send_request($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT,
                         pick_value(stim_modulus));
            if ($urandom_range(0, 39) == 0)
               drain();
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
